FILE: hw/rtl/mppt_incremental_conductance_macros.svh
// Assertion macros used by the incremental conductance tracker core.
`ifndef MPPT_INCREMENTAL_CONDUCTANCE_MACROS_SVH
`define MPPT_INCREMENTAL_CONDUCTANCE_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define MIC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define MIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MIC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/mppt_ic_pkg.sv
// Shared types, constants and register codes of the incremental conductance tracker.
`default_nettype none

package mppt_ic_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int PWM_BITS_DEF    = 8;

  localparam int DUTY_BITS = 16;
  localparam int BAND_BITS = 12;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  // register indexes, byte address = 4 * index
  localparam logic [REG_IDX_W-1:0] REG_FINE_BAND    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COARSE_STEP  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FINE_STEP    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DUTY_FLOOR   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DUTY_CEILING = 3'd4;

  localparam logic [BAND_BITS-1:0] FINE_BAND_RST    = 12'd1;
  localparam logic [DUTY_BITS-1:0] COARSE_STEP_RST  = 16'd655;
  localparam logic [DUTY_BITS-1:0] FINE_STEP_RST    = 16'd66;
  localparam logic [DUTY_BITS-1:0] DUTY_FLOOR_RST   = 16'd3277;
  localparam logic [DUTY_BITS-1:0] DUTY_CEILING_RST = 16'd62259;
  localparam logic [DUTY_BITS-1:0] DUTY_HALF        = 16'd32768;

  typedef struct packed {
    logic [BAND_BITS-1:0] fine_band;
    logic [DUTY_BITS-1:0] coarse_step;
    logic [DUTY_BITS-1:0] fine_step;
    logic [DUTY_BITS-1:0] duty_floor;
    logic [DUTY_BITS-1:0] duty_ceiling;
  } cfg_t;

  typedef struct packed {
    logic at_peak;
    logic fine_mode;
  } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mppt_ic_regs.sv
// APB configuration registers of the incremental conductance tracker.
`default_nettype none

module mppt_ic_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mppt_ic_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [mppt_ic_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [mppt_ic_pkg::APB_DATA_W-1:0] prdata,
  output logic                                    pready,
  output mppt_ic_pkg::cfg_t                       cfg
);
  import mppt_ic_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FINE_BAND:    cfg_nxt.fine_band    = pwdata[BAND_BITS-1:0];
        REG_COARSE_STEP:  cfg_nxt.coarse_step  = pwdata[DUTY_BITS-1:0];
        REG_FINE_STEP:    cfg_nxt.fine_step    = pwdata[DUTY_BITS-1:0];
        REG_DUTY_FLOOR:   cfg_nxt.duty_floor   = pwdata[DUTY_BITS-1:0];
        REG_DUTY_CEILING: cfg_nxt.duty_ceiling = pwdata[DUTY_BITS-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FINE_BAND:    prdata = APB_DATA_W'(cfg_r.fine_band);
      REG_COARSE_STEP:  prdata = APB_DATA_W'(cfg_r.coarse_step);
      REG_FINE_STEP:    prdata = APB_DATA_W'(cfg_r.fine_step);
      REG_DUTY_FLOOR:   prdata = APB_DATA_W'(cfg_r.duty_floor);
      REG_DUTY_CEILING: prdata = APB_DATA_W'(cfg_r.duty_ceiling);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fine_band    <= FINE_BAND_RST;
      cfg_r.coarse_step  <= COARSE_STEP_RST;
      cfg_r.fine_step    <= FINE_STEP_RST;
      cfg_r.duty_floor   <= DUTY_FLOOR_RST;
      cfg_r.duty_ceiling <= DUTY_CEILING_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mppt_ic_core.sv
// Tracker state and combinational incremental conductance decision and duty update.
`default_nettype none
`include "mppt_incremental_conductance_macros.svh"

module mppt_ic_core #(
  parameter int SAMPLE_BITS = mppt_ic_pkg::SAMPLE_BITS_DEF,
  parameter int PWM_BITS    = mppt_ic_pkg::PWM_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              step_en,
  input  wire logic [SAMPLE_BITS-1:0]            voltage,
  input  wire logic [SAMPLE_BITS-1:0]            current,
  input  wire mppt_ic_pkg::cfg_t                 cfg,
  output logic      [mppt_ic_pkg::DUTY_BITS-1:0] duty_value,
  output logic      [PWM_BITS-1:0]               pwm_level,
  output mppt_ic_pkg::stat_t                     stat
);
  import mppt_ic_pkg::*;

  localparam int DIFF_W  = SAMPLE_BITS + 1;
  localparam int PROD_W  = 2 * SAMPLE_BITS + 2;
  localparam int SUM_W   = PROD_W + 1;
  localparam int POW_W   = 2 * SAMPLE_BITS;
  localparam int DP_W    = POW_W + 1;
  localparam int DSUM_W  = DUTY_BITS + 2;
  localparam int CMP_W   = (SAMPLE_BITS > BAND_BITS) ? SAMPLE_BITS : BAND_BITS;
  localparam int SCALE_W = DUTY_BITS + PWM_BITS;

  logic [SAMPLE_BITS-1:0] last_voltage_r;
  logic [SAMPLE_BITS-1:0] last_current_r;
  logic [POW_W-1:0]       last_power_r;
  logic [DUTY_BITS-1:0]   duty_now_r;

  logic signed [DIFF_W-1:0] dv;
  logic signed [DIFF_W-1:0] di;
  logic signed [DIFF_W-1:0] v_s;
  logic signed [DIFF_W-1:0] i_s;
  logic signed [PROD_W-1:0] di_v;
  logic signed [PROD_W-1:0] i_dv;
  logic signed [SUM_W-1:0]  cross_sum;
  logic signed [SUM_W-1:0]  cross_adj;
  logic [POW_W-1:0]         power;
  logic signed [DP_W-1:0]   dp;
  logic [SAMPLE_BITS-1:0]   dv_mag;
  logic                     fine;
  logic                     step_up;
  logic                     step_down;
  logic                     peak;
  logic [DUTY_BITS-1:0]     duty_step;
  logic signed [DSUM_W-1:0] duty_sum;
  logic signed [DSUM_W-1:0] floor_s;
  logic signed [DSUM_W-1:0] ceil_s;
  logic [DUTY_BITS-1:0]     duty_clamped;
  logic [DUTY_BITS-1:0]     duty_nxt;
  logic [SCALE_W-1:0]       duty_scaled;

  assign v_s = $signed({1'b0, voltage});
  assign i_s = $signed({1'b0, current});
  assign dv  = v_s - $signed({1'b0, last_voltage_r});
  assign di  = i_s - $signed({1'b0, last_current_r});

  // dI*V + I*dV, sign flipped for a falling voltage
  assign di_v      = PROD_W'(di) * PROD_W'(v_s);
  assign i_dv      = PROD_W'(i_s) * PROD_W'(dv);
  assign cross_sum = SUM_W'(di_v) + SUM_W'(i_dv);
  assign cross_adj = dv[DIFF_W-1] ? -cross_sum : cross_sum;

  assign power = POW_W'(voltage) * POW_W'(current);
  assign dp    = $signed({1'b0, power}) - $signed({1'b0, last_power_r});

  assign dv_mag = dv[DIFF_W-1] ? SAMPLE_BITS'(-dv) : SAMPLE_BITS'(dv);
  assign fine   = CMP_W'(dv_mag) < CMP_W'(cfg.fine_band);

  always_comb begin
    if (dv == '0) begin
      step_up   = !dp[DP_W-1] && (dp != '0);
      step_down = dp[DP_W-1];
    end else begin
      step_up   = !cross_adj[SUM_W-1] && (cross_adj != '0);
      step_down = cross_adj[SUM_W-1];
    end
  end

  assign peak      = !step_up && !step_down;
  assign duty_step = fine ? cfg.fine_step : cfg.coarse_step;
  assign duty_sum  = step_up ? $signed({2'b00, duty_now_r}) + $signed({2'b00, duty_step})
                             : $signed({2'b00, duty_now_r}) - $signed({2'b00, duty_step});
  assign floor_s   = $signed({2'b00, cfg.duty_floor});
  assign ceil_s    = $signed({2'b00, cfg.duty_ceiling});

  // floor above the ceiling: a sum below the floor takes the floor, any other the ceiling
  always_comb begin
    priority if (duty_sum < floor_s) begin
      duty_clamped = cfg.duty_floor;
    end else if (duty_sum > ceil_s) begin
      duty_clamped = cfg.duty_ceiling;
    end else begin
      duty_clamped = duty_sum[DUTY_BITS-1:0];
    end
  end

  assign duty_nxt = peak ? duty_now_r : duty_clamped;

  // duty * (2^PWM_BITS - 1) as shift and subtract, keep the bits above Q0.16
  assign duty_scaled = {duty_nxt, PWM_BITS'(0)} - SCALE_W'(duty_nxt);

  assign duty_value     = duty_nxt;
  assign pwm_level      = duty_scaled[DUTY_BITS +: PWM_BITS];
  assign stat.at_peak   = peak;
  assign stat.fine_mode = fine;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_voltage_r <= '0;
      last_current_r <= '0;
      last_power_r   <= '0;
      duty_now_r     <= DUTY_HALF;
    end else if (step_en && !peak) begin
      last_voltage_r <= voltage;
      last_current_r <= current;
      last_power_r   <= power;
      duty_now_r     <= duty_clamped;
    end
  end

  `MIC_ASSERT_NEXT(a_peak_holds, clk, rst_n, step_en && peak, $stable(duty_now_r) && $stable(last_power_r), "duty or history moved at the peak")
  `MIC_ASSERT_NEXT(a_history_taken, clk, rst_n, step_en && !peak, last_voltage_r == $past(voltage) && last_current_r == $past(current), "history not updated after a step")
  `MIC_ASSERT_NEXT(a_duty_clamped, clk, rst_n, step_en && !peak, duty_now_r >= $past(cfg.duty_floor) || duty_now_r == $past(cfg.duty_ceiling), "duty left the clamp range")

endmodule

`default_nettype wire

FILE: hw/rtl/mppt_incremental_conductance.sv
// Top level of the incremental conductance maximum power point tracker.
`default_nettype none

// Takes one voltage/current sample pair per beat and returns one beat per pair: the
// new Q0.16 duty, its PWM level, and the peak and fine-step flags. One pair is taken
// every clock cycle while the output is not held back; a result passes the input
// register, then the result register, before it is presented on the output. The
// rate is set by the state loop: the two cross products, the duty add and the
// clamp are combinational so that each pair sees the history left by the one
// before. in_tready falls only while both the input register and the result
// register hold beats and out_tready is low.
// Registers (APB, byte address 4*i): fine_band, coarse_step, fine_step, duty_floor,
// duty_ceiling.
module mppt_incremental_conductance #(
  parameter int SAMPLE_BITS = mppt_ic_pkg::SAMPLE_BITS_DEF,
  parameter int PWM_BITS    = mppt_ic_pkg::PWM_BITS_DEF,
  parameter int IN_DATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  parameter int OUT_DATA_W  = ((mppt_ic_pkg::DUTY_BITS + PWM_BITS + 2 + 7) / 8) * 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // voltage_sample, current_sample, zero pad
  input  wire logic [IN_DATA_W-1:0]               in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // duty_value, pwm_level, at_peak, fine_mode, zero pad
  output logic      [OUT_DATA_W-1:0]              out_tdata,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [mppt_ic_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [mppt_ic_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic      [mppt_ic_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                                    cfg_pready
);
  import mppt_ic_pkg::*;

  localparam int FIELD_W = DUTY_BITS + PWM_BITS + 2;

  cfg_t cfg;

  logic                   s0_valid_r;
  logic                   s0_valid_nxt;
  logic [SAMPLE_BITS-1:0] s0_voltage_r;
  logic [SAMPLE_BITS-1:0] s0_current_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [FIELD_W-1:0]     out_fields_r;

  logic                   in_beat;
  logic                   out_free;
  logic                   step_en;
  logic [DUTY_BITS-1:0]   duty_value;
  logic [PWM_BITS-1:0]    pwm_level;
  stat_t                  stat;

  mppt_ic_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  mppt_ic_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .PWM_BITS    (PWM_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .voltage    (s0_voltage_r),
    .current    (s0_current_r),
    .cfg        (cfg),
    .duty_value (duty_value),
    .pwm_level  (pwm_level),
    .stat       (stat)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign step_en   = s0_valid_r && out_free;
  assign in_tready = !s0_valid_r || out_free;
  assign in_beat   = in_tvalid && in_tready;

  assign s0_valid_nxt  = in_beat ? 1'b1 : (step_en ? 1'b0 : s0_valid_r);
  assign out_valid_nxt = step_en ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s0_voltage_r <= in_tdata[SAMPLE_BITS-1:0];
      s0_current_r <= in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end
    if (step_en) begin
      out_fields_r <= {stat.fine_mode, stat.at_peak, pwm_level, duty_value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_fields_r);

endmodule

`default_nettype wire
